// ===== rtl/swpfc_pkg.sv =====
// Shared constants, register codes and cell types for the purine frame counter.
`default_nettype none
package swpfc_pkg;

  // Capacity of the purine ring and of the frame counter row.
  localparam int MAX_WINDOW = 1024;
  localparam int MAX_PERIOD = 8;

  // Widths derived from the capacities.
  localparam int RING_AW = $clog2(MAX_WINDOW);
  localparam int EWIN_W  = $clog2(MAX_WINDOW + 1);

  // Widths fixed by the register map and the result fields.
  localparam int POS_W      = 32;
  localparam int WINREG_W   = 11;
  localparam int STEP_W     = 16;
  localparam int PERREG_W   = 4;
  localparam int FRAME_W    = 3;
  localparam int CNT_W      = 11;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int DIV_STEP_W = $clog2(POS_W);

  // Character codes of interest.
  localparam logic [BYTE_W-1:0] CHAR_A = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_G = 8'h67;
  localparam logic [BYTE_W-1:0] CHAR_Z = 8'h7a;

  // Register reset values.
  localparam logic [POS_W-1:0]    START_RST  = 32'd1;
  localparam logic [POS_W-1:0]    END_RST    = 32'hffff_ffff;
  localparam logic [WINREG_W-1:0] WINDOW_RST = 11'd201;
  localparam logic [STEP_W-1:0]   STEP_RST   = 16'd51;
  localparam logic [PERREG_W-1:0] PERIOD_RST = 4'd3;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_START  = 3'd0,
    REG_END    = 3'd1,
    REG_WINDOW = 3'd2,
    REG_STEP   = 3'd3,
    REG_PERIOD = 3'd4
  } reg_idx_e;

  // One result slot held in a cell of the output row.
  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] idx;
    logic [CNT_W-1:0]   count;
    logic               last;
  } res_slot_t;

  // Control broadcast from the pipeline to every cell.
  typedef struct packed {
    logic               upd;
    logic               inc;
    logic               dec;
    logic [FRAME_W-1:0] frame;
    logic               load;
    logic               adv;
    logic [FRAME_W-1:0] last_idx;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/swpfc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module swpfc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; a read of the address being written returns old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/swpfc_phase_div.sv =====
// Bit-serial remainder unit that finds the frame phase of the position counter.
`default_nettype none
module swpfc_phase_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [swpfc_pkg::POS_W-1:0]        dividend_i,
  input  logic [swpfc_pkg::PERREG_W-1:0]     divisor_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [swpfc_pkg::FRAME_W-1:0]      rem_o
);

  logic                                  busy_q;
  logic [swpfc_pkg::DIV_STEP_W-1:0]      step_q;
  logic [swpfc_pkg::POS_W-1:0]           dv_q;
  logic [swpfc_pkg::FRAME_W-1:0]         rem_q;
  logic [swpfc_pkg::FRAME_W:0]           trial;
  logic [swpfc_pkg::FRAME_W:0]           reduced;

  // One restoring step: bring down the next dividend bit and subtract if it fits.
  always_comb begin
    trial   = {rem_q, dv_q[swpfc_pkg::POS_W-1]};
    reduced = (trial >= (swpfc_pkg::FRAME_W+1)'(divisor_i))
              ? trial - (swpfc_pkg::FRAME_W+1)'(divisor_i) : trial;
  end

  assign busy_o = busy_q;
  assign done_o = busy_q && (step_q == '1);
  assign rem_o  = reduced[swpfc_pkg::FRAME_W-1:0];

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == '1) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Dividend shifter and partial remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dv_q  <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dv_q  <= {dv_q[swpfc_pkg::POS_W-2:0], 1'b0};
      rem_q <= reduced[swpfc_pkg::FRAME_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/swpfc_cell.sv =====
// One frame cell: a purine counter for its frame and one slot of the result row.
`default_nettype none
module swpfc_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [swpfc_pkg::FRAME_W-1:0]  idx_i,
  input  swpfc_pkg::cell_ctrl_t          ctrl_i,
  input  swpfc_pkg::res_slot_t           nb_i,
  output swpfc_pkg::res_slot_t           res_o
);

  logic [swpfc_pkg::CNT_W-1:0] count_q;
  swpfc_pkg::res_slot_t        res_q;
  logic                        hit;

  assign hit = ctrl_i.upd && (ctrl_i.frame == idx_i);

  // Frame counter: wraps at its width like the stored count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (hit && ctrl_i.inc) begin
      count_q <= count_q + 1'b1;
    end else if (hit && ctrl_i.dec) begin
      count_q <= count_q - 1'b1;
    end
  end

  // Result slot: takes a snapshot on a report, otherwise moves toward the output when the row advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (ctrl_i.load) begin
      res_q.valid <= (idx_i <= ctrl_i.last_idx);
      res_q.idx   <= idx_i;
      res_q.count <= count_q;
      res_q.last  <= (idx_i == ctrl_i.last_idx);
    end else if (ctrl_i.adv) begin
      res_q <= nb_i;
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

// ===== rtl/sliding_window_purine_frame_count_unit.sv =====
// Sliding-window purine counter per reading frame, one sequence byte per request.
// Throughput: one byte per cycle unless stalled; a byte that may close a report stalls
// input while it is in the update stage, and a report waits in a pending register until
// the result row has drained, then leaves one result per cycle while res_stall_i is low.
// Reset clears counters and marks at once (ring entries above the fill mark read as zero);
// a write to frame_period stalls input while the frame phase is recomputed.
`default_nettype none
module sliding_window_purine_frame_count_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swpfc_pkg::ADDR_W-1:0]        paddr,
  input  logic [swpfc_pkg::DATA_W-1:0]        pwdata,
  output logic [swpfc_pkg::DATA_W-1:0]        prdata,
  output logic                                pready,
  input  logic                                seq_valid_i,
  output logic                                seq_stall_o,
  input  logic [swpfc_pkg::BYTE_W-1:0]        seq_byte_i,
  output logic                                res_valid_o,
  input  logic                                res_stall_i,
  output logic [swpfc_pkg::POS_W-1:0]         center_position_o,
  output logic [swpfc_pkg::FRAME_W-1:0]       frame_index_o,
  output logic [swpfc_pkg::CNT_W-1:0]         purine_count_o,
  output logic                                last_frame_o
);

  // Configuration registers.
  logic [swpfc_pkg::POS_W-1:0]    start_q;
  logic [swpfc_pkg::POS_W-1:0]    end_q;
  logic [swpfc_pkg::WINREG_W-1:0] win_q;
  logic [swpfc_pkg::STEP_W-1:0]   step_q;
  logic [swpfc_pkg::PERREG_W-1:0] per_q;
  swpfc_pkg::reg_idx_e            reg_sel;
  logic                           cfg_we;

  // Effective settings.
  logic [swpfc_pkg::EWIN_W-1:0]   win_eff;
  logic [swpfc_pkg::STEP_W-1:0]   stp_eff;
  logic [swpfc_pkg::PERREG_W-1:0] per_eff;
  logic [swpfc_pkg::FRAME_W-1:0]  last_idx;
  logic [swpfc_pkg::POS_W-1:0]    win32;

  // Position and window state.
  logic [swpfc_pkg::POS_W-1:0]    lp_q;
  logic [swpfc_pkg::POS_W-1:0]    cnt_q;
  logic [swpfc_pkg::RING_AW-1:0]  rp_q;
  logic [swpfc_pkg::EWIN_W-1:0]   hw_q;
  logic [swpfc_pkg::STEP_W-1:0]   sp_q;
  logic [swpfc_pkg::FRAME_W-1:0]  phase_q;

  // Entry stage signals.
  logic                           in_acc;
  logic                           is_letter;
  logic                           stop;
  logic                           active;
  logic                           lp_sat;
  logic [swpfc_pkg::POS_W-1:0]    lp_n;
  logic                           in_rng;
  logic                           proc;
  logic [swpfc_pkg::RING_AW-1:0]  slot;
  logic [swpfc_pkg::EWIN_W-1:0]   slot_inc;
  logic [swpfc_pkg::RING_AW-1:0]  rp_n;
  logic [swpfc_pkg::EWIN_W-1:0]   hw_n;
  logic                           rd_ok;
  logic [swpfc_pkg::POS_W-1:0]    cnt_n;
  logic [swpfc_pkg::STEP_W-1:0]   sp1;
  logic [swpfc_pkg::STEP_W:0]     sp2;
  logic [swpfc_pkg::STEP_W-1:0]   sp_n;
  logic                           cand;
  logic [swpfc_pkg::PERREG_W-1:0] phase_inc;
  logic [swpfc_pkg::FRAME_W-1:0]  phase_n;

  // Update stage registers.
  logic                           s1_valid_q;
  logic [swpfc_pkg::RING_AW-1:0]  s1_slot_q;
  logic [swpfc_pkg::FRAME_W-1:0]  s1_frame_q;
  logic                           s1_pur_q;
  logic                           s1_fwd_q;
  logic                           s1_fwdv_q;
  logic                           s1_rdok_q;
  logic                           s1_cand_q;
  logic [swpfc_pkg::POS_W-1:0]    s1_cnt_q;

  // Update stage signals.
  logic                           rdata;
  logic                           old_mark;
  logic [swpfc_pkg::POS_W:0]      sum1;
  logic                           report;
  logic [swpfc_pkg::POS_W-1:0]    center;

  // Report hand-off and result row.
  logic                           pend_q;
  logic [swpfc_pkg::POS_W-1:0]    pcen_q;
  logic [swpfc_pkg::POS_W-1:0]    ocen_q;
  logic                           can_load;
  logic                           adv;
  logic                           load;
  swpfc_pkg::cell_ctrl_t          cell_ctrl;
  swpfc_pkg::res_slot_t           chain [swpfc_pkg::MAX_PERIOD+1];

  // Phase recompute unit.
  logic                           div_start;
  logic [swpfc_pkg::POS_W-1:0]    div_dvd;
  logic                           div_busy;
  logic                           div_done;
  logic [swpfc_pkg::FRAME_W-1:0]  div_rem;

  // Register port decode.
  assign reg_sel = swpfc_pkg::reg_idx_e'(paddr[swpfc_pkg::ADDR_W-1:2]);
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= swpfc_pkg::START_RST;
      end_q   <= swpfc_pkg::END_RST;
      win_q   <= swpfc_pkg::WINDOW_RST;
      step_q  <= swpfc_pkg::STEP_RST;
      per_q   <= swpfc_pkg::PERIOD_RST;
    end else if (cfg_we) begin
      unique case (reg_sel)
        swpfc_pkg::REG_START:  start_q <= pwdata;
        swpfc_pkg::REG_END:    end_q   <= pwdata;
        swpfc_pkg::REG_WINDOW: win_q   <= pwdata[swpfc_pkg::WINREG_W-1:0];
        swpfc_pkg::REG_STEP:   step_q  <= pwdata[swpfc_pkg::STEP_W-1:0];
        swpfc_pkg::REG_PERIOD: per_q   <= pwdata[swpfc_pkg::PERREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      swpfc_pkg::REG_START:  prdata = start_q;
      swpfc_pkg::REG_END:    prdata = end_q;
      swpfc_pkg::REG_WINDOW: prdata = swpfc_pkg::DATA_W'(win_q);
      swpfc_pkg::REG_STEP:   prdata = swpfc_pkg::DATA_W'(step_q);
      swpfc_pkg::REG_PERIOD: prdata = swpfc_pkg::DATA_W'(per_q);
      default:               prdata = '0;
    endcase
  end

  // Clamp the settings to their usable ranges.
  always_comb begin
    if (win_q == '0) begin
      win_eff = swpfc_pkg::EWIN_W'(1);
    end else if (32'(win_q) > swpfc_pkg::MAX_WINDOW) begin
      win_eff = swpfc_pkg::EWIN_W'(swpfc_pkg::MAX_WINDOW);
    end else begin
      win_eff = swpfc_pkg::EWIN_W'(win_q);
    end
    if (per_q == '0) begin
      per_eff = swpfc_pkg::PERREG_W'(1);
    end else if (32'(per_q) > swpfc_pkg::MAX_PERIOD) begin
      per_eff = swpfc_pkg::PERREG_W'(swpfc_pkg::MAX_PERIOD);
    end else begin
      per_eff = per_q;
    end
    stp_eff  = (step_q == '0) ? swpfc_pkg::STEP_W'(1) : step_q;
    last_idx = swpfc_pkg::FRAME_W'(per_eff - 1'b1);
    win32    = swpfc_pkg::POS_W'(win_eff);
  end

  // Entry stage: classify the byte, advance the position and pick the ring slot.
  assign in_acc    = seq_valid_i && !seq_stall_o;
  assign is_letter = (seq_byte_i >= swpfc_pkg::CHAR_A) && (seq_byte_i <= swpfc_pkg::CHAR_Z);
  assign stop      = ({1'b0, start_q} + {1'b0, cnt_q}) > {1'b0, end_q};
  assign active    = in_acc && !stop && is_letter;
  assign lp_sat    = (lp_q == '1);
  assign lp_n      = lp_sat ? lp_q : lp_q + 1'b1;
  assign in_rng    = (lp_n >= start_q) && (lp_n <= end_q);
  assign proc      = active && in_rng;

  always_comb begin
    slot     = (swpfc_pkg::EWIN_W'(rp_q) >= win_eff) ? '0 : rp_q;
    slot_inc = swpfc_pkg::EWIN_W'(slot) + swpfc_pkg::EWIN_W'(1);
    rp_n     = (slot_inc >= win_eff) ? '0 : slot_inc[swpfc_pkg::RING_AW-1:0];
    hw_n     = (slot_inc > hw_q) ? slot_inc : hw_q;
    rd_ok    = swpfc_pkg::EWIN_W'(slot) < hw_q;
    cnt_n    = cnt_q + 1'b1;
  end

  // Step phase: a report is due when the window first fills and every step after.
  always_comb begin
    sp1  = (sp_q >= stp_eff) ? '0 : sp_q;
    sp2  = {1'b0, sp1} + 1'b1;
    sp_n = sp_q;
    cand = 1'b0;
    if (cnt_n == win32) begin
      sp_n = '0;
      cand = 1'b1;
    end else if (cnt_n > win32) begin
      sp_n = (sp2 >= {1'b0, stp_eff}) ? '0 : sp2[swpfc_pkg::STEP_W-1:0];
      cand = (sp_n == '0);
    end
  end

  // Frame phase of the next position.
  assign phase_inc = swpfc_pkg::PERREG_W'(phase_q) + 1'b1;
  assign phase_n   = (phase_inc == per_eff) ? '0 : phase_inc[swpfc_pkg::FRAME_W-1:0];

  // The phase holds still once the next position is the saturated one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q    <= '0;
      cnt_q   <= '0;
      rp_q    <= '0;
      hw_q    <= '0;
      sp_q    <= '0;
      phase_q <= '0;
    end else begin
      if (active) begin
        lp_q <= lp_n;
      end
      if (div_done) begin
        phase_q <= div_rem;
      end else if (active && (lp_n != '1)) begin
        phase_q <= phase_n;
      end
      if (proc) begin
        rp_q  <= rp_n;
        hw_q  <= hw_n;
        cnt_q <= cnt_n;
        sp_q  <= sp_n;
      end
    end
  end

  // Update stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= proc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      s1_slot_q  <= slot;
      s1_frame_q <= phase_q;
      s1_pur_q   <= (seq_byte_i == swpfc_pkg::CHAR_A) || (seq_byte_i == swpfc_pkg::CHAR_G);
      s1_fwd_q   <= s1_valid_q && (s1_slot_q == slot);
      s1_fwdv_q  <= s1_pur_q;
      s1_rdok_q  <= rd_ok;
      s1_cand_q  <= cand;
      s1_cnt_q   <= cnt_n;
    end
  end

  // Purine ring: read at entry, written back in the update stage.
  swpfc_ram #(
    .WIDTH (1),
    .DEPTH (swpfc_pkg::MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_slot_q),
    .wdata_i (s1_pur_q),
    .re_i    (proc),
    .raddr_i (slot),
    .rdata_o (rdata)
  );

  // Old mark of the slot, forwarded when the previous base wrote the same slot.
  assign old_mark = s1_fwd_q ? s1_fwdv_q : (s1_rdok_q && rdata);

  // Report check and window centre.
  assign sum1   = {1'b0, start_q} + {1'b0, s1_cnt_q};
  assign report = s1_valid_q && s1_cand_q && (sum1 < {1'b0, end_q});
  assign center = sum1[swpfc_pkg::POS_W-1:0]
                  - (swpfc_pkg::POS_W'(win_eff >> 1) + swpfc_pkg::POS_W'(1));

  // Result row hand-off.
  assign adv      = !chain[0].valid || !res_stall_i;
  assign can_load = !chain[1].valid && adv;
  assign load     = pend_q && can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (report) begin
      pend_q <= 1'b1;
    end else if (load) begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (report) begin
      pcen_q <= center;
    end
    if (load) begin
      ocen_q <= pcen_q;
    end
  end

  // Input stall: phase recompute, a possible report in flight, or a report waiting.
  assign seq_stall_o = div_busy || (s1_valid_q && s1_cand_q) || (pend_q && !can_load);

  // Control broadcast to the cells.
  always_comb begin
    cell_ctrl.upd      = s1_valid_q;
    cell_ctrl.inc      = s1_pur_q && !old_mark;
    cell_ctrl.dec      = !s1_pur_q && old_mark;
    cell_ctrl.frame    = s1_frame_q;
    cell_ctrl.load     = load;
    cell_ctrl.adv      = adv;
    cell_ctrl.last_idx = last_idx;
  end

  // Row of frame cells; results shift toward cell zero.
  assign chain[swpfc_pkg::MAX_PERIOD] = '0;

  for (genvar j = 0; j < swpfc_pkg::MAX_PERIOD; j++) begin : g_cell
    swpfc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (swpfc_pkg::FRAME_W'(j)),
      .ctrl_i (cell_ctrl),
      .nb_i   (chain[j+1]),
      .res_o  (chain[j])
    );
  end

  assign res_valid_o       = chain[0].valid;
  assign center_position_o = ocen_q;
  assign frame_index_o     = chain[0].idx;
  assign purine_count_o    = chain[0].count;
  assign last_frame_o      = chain[0].last;

  // Frame phase recompute after a period change; a saturated position repeats its frame.
  assign div_start = cfg_we && (reg_sel == swpfc_pkg::REG_PERIOD);
  assign div_dvd   = lp_sat ? lp_q - 1'b1 : lp_q;

  swpfc_phase_div u_phase_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (per_eff),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

`ifndef NO_ASSERTIONS
  // Counters stay frozen while a report waits for the result row.
  a_pend_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !s1_valid_q)
    else $error("frame counter updated while a report was pending");

  // The final result of a report is the last one in the row.
  a_last_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && last_frame_o) |-> !chain[1].valid)
    else $error("results queued behind the last frame of a report");

  // Results of one report leave in rising frame order with no gap.
  a_frame_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_stall_i && !last_frame_o) |=>
      (res_valid_o && (frame_index_o == swpfc_pkg::FRAME_W'($past(frame_index_o) + 1'b1))))
    else $error("frame results out of order");

  // The frame phase stays below the period whenever it is in use.
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !div_busy |-> (swpfc_pkg::PERREG_W'(phase_q) < per_eff))
    else $error("frame phase outside the period");
`endif

endmodule
`default_nettype wire
